@@ rtl/core/vmc_pkg.sv @@
// Shared types, widths and arithmetic helpers for the vertex transform pipeline.
`default_nettype none
package vmc_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned PROD_W     = 48;  // 64-bit product after >>> 16
  localparam int unsigned SUM_W      = 50;  // four products summed exactly
  localparam int unsigned MAT_N      = 16;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 256;

  localparam logic signed [Q_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MODEL = 2'd0,
    OP_LOAD_PROJ  = 2'd1,
    OP_TRANSFORM  = 2'd2
  } op_t;

  // floor(a * b / 2^16), exact
  function automatic logic signed [PROD_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [2*Q_W-1:0] p;
    p = a * b;
    return p[2*Q_W-1:16];
  endfunction

  function automatic logic signed [SUM_W-1:0] add4(input logic signed [PROD_W-1:0] a,
                                                   input logic signed [PROD_W-1:0] b,
                                                   input logic signed [PROD_W-1:0] c,
                                                   input logic signed [PROD_W-1:0] d);
    logic signed [SUM_W-1:0] ea, eb, ec, ed;
    ea = {{(SUM_W-PROD_W){a[PROD_W-1]}}, a};
    eb = {{(SUM_W-PROD_W){b[PROD_W-1]}}, b};
    ec = {{(SUM_W-PROD_W){c[PROD_W-1]}}, c};
    ed = {{(SUM_W-PROD_W){d[PROD_W-1]}}, d};
    return ea + eb + ec + ed;
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] res;
    if (!v[SUM_W-1] && (|v[SUM_W-2:Q_W-1])) begin
      res = S32_MAX;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:Q_W-1])) begin
      res = S32_MIN;
    end else begin
      res = v[Q_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/vertex_model_to_clip_transform.sv @@
// A transform word passes stage 1, stage 2, stage 3, stage 4 and the output register to out_tvalid.
// Throughput: one word per cycle unless the output stalls; each stage has its own valid bit
// and moves when the stage after it is empty or moving, so bubbles close up behind a stalled output.
// Loads give no output word; model loads write at stage 1, projection loads at stage 3.
// Reset (rst_n low, synchronous) clears both matrices and all valid bits.
`default_nettype none
module vertex_model_to_clip_transform
  import vmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // elem_index, elem_value, pos_x, pos_y, pos_z, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // eye_x, eye_y, eye_z, eye_w, clip_x, clip_y, clip_z, clip_w
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic signed [Q_W-1:0] model_r [MAT_N];
  logic signed [Q_W-1:0] proj_r  [MAT_N];

  // stage 1: input register
  logic                  v1_r;
  op_t                   op1_r;
  logic [IDX_W-1:0]      idx1_r;
  logic signed [Q_W-1:0] val1_r;
  logic signed [Q_W-1:0] pos1_r [3];

  // stage 2: model products
  logic                     v2_r;
  op_t                      op2_r;
  logic [IDX_W-1:0]         idx2_r;
  logic signed [Q_W-1:0]    val2_r;
  logic signed [PROD_W-1:0] mp2_r  [4][4];
  logic signed [PROD_W-1:0] mp_nxt [4][4];

  // stage 3: eye vector
  logic                  v3_r;
  op_t                   op3_r;
  logic [IDX_W-1:0]      idx3_r;
  logic signed [Q_W-1:0] val3_r;
  logic signed [Q_W-1:0] eye3_r  [4];
  logic signed [Q_W-1:0] eye_nxt [4];

  // stage 4: projection products
  logic                     v4_r;
  logic signed [Q_W-1:0]    eye4_r [4];
  logic signed [PROD_W-1:0] pp4_r  [4][4];
  logic signed [PROD_W-1:0] pp_nxt [4][4];

  // output register
  logic                  out_v_r;
  logic signed [Q_W-1:0] eye_o_r  [4];
  logic signed [Q_W-1:0] clip_o_r [4];
  logic signed [Q_W-1:0] clip_nxt [4];

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic mv1, mv2, mv3, mv4;

  // per-stage flow control
  always_comb begin
    rdy5 = !out_v_r || out_tready;
    mv4  = v4_r && rdy5;
    rdy4 = !v4_r || mv4;
    mv3  = v3_r && ((op3_r != OP_TRANSFORM) || rdy4);
    rdy3 = !v3_r || mv3;
    mv2  = v2_r && rdy3;
    rdy2 = !v2_r || mv2;
    mv1  = v1_r && rdy2;
    rdy1 = !v1_r || mv1;
  end

  assign in_tready = rdy1;

  // translation column enters as the fourth term, w = 1 is exact
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        mp_nxt[r][c] = qmul(pos1_r[c], model_r[r + 4*c]);
      end
      mp_nxt[r][3] = {{(PROD_W-Q_W){model_r[r + 12][Q_W-1]}}, model_r[r + 12]};
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      eye_nxt[r] = sat32(add4(mp2_r[r][0], mp2_r[r][1], mp2_r[r][2], mp2_r[r][3]));
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pp_nxt[r][c] = qmul(eye3_r[c], proj_r[r + 4*c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip_nxt[r] = sat32(add4(pp4_r[r][0], pp4_r[r][1], pp4_r[r][2], pp4_r[r][3]));
    end
  end

  // control and matrices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < MAT_N; i++) begin
        model_r[i] <= '0;
        proj_r[i]  <= '0;
      end
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r && (op3_r == OP_TRANSFORM);
      if (rdy5) out_v_r <= v4_r;
      // matrix writes happen where the matrix is read, so order is kept
      if (mv1 && (op1_r == OP_LOAD_MODEL)) model_r[idx1_r] <= val1_r;
      if (mv3 && (op3_r == OP_LOAD_PROJ))  proj_r[idx3_r]  <= val3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r     <= op_t'(in_tuser);
      idx1_r    <= in_tdata[3:0];
      val1_r    <= in_tdata[35:4];
      pos1_r[0] <= in_tdata[67:36];
      pos1_r[1] <= in_tdata[99:68];
      pos1_r[2] <= in_tdata[131:100];
    end
    if (rdy2) begin
      op2_r  <= op1_r;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      mp2_r  <= mp_nxt;
    end
    if (rdy3) begin
      op3_r  <= op2_r;
      idx3_r <= idx2_r;
      val3_r <= val2_r;
      eye3_r <= eye_nxt;
    end
    if (rdy4) begin
      eye4_r <= eye3_r;
      pp4_r  <= pp_nxt;
    end
    if (rdy5) begin
      eye_o_r  <= eye4_r;
      clip_o_r <= clip_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {clip_o_r[3], clip_o_r[2], clip_o_r[1], clip_o_r[0],
                       eye_o_r[3], eye_o_r[2], eye_o_r[1], eye_o_r[0]};

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted word not held in stage 1");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_tdata))
    else $error("stalled output word lost or changed");

  a_model_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mv1 && (op1_r == OP_LOAD_MODEL) |=> model_r[$past(idx1_r)] == $past(val1_r))
    else $error("model load not written");

  a_proj_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mv3 && (op3_r == OP_LOAD_PROJ) |=> proj_r[$past(idx3_r)] == $past(val3_r))
    else $error("projection load not written");

  a_no_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    rdy4 && v3_r && (op3_r != OP_TRANSFORM) |=> !v4_r)
    else $error("load word entered projection stage");

endmodule
`default_nettype wire

@@ verif/vertex_model_to_clip_transform_tb.sv @@
// Self-checking testbench for the model-to-clip vertex transform pipeline.
`timescale 1ns / 100ps
module vertex_model_to_clip_transform_tb;
  import vmc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [Q_W-1:0]  Q_ONE     = 32'h0001_0000;
  localparam int              QUIET_MAX = 4000;
  localparam logic [31:0]     AXES      = "wzyx";

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [Q_W-1:0]   val;
    logic [Q_W-1:0]   px;
    logic [Q_W-1:0]   py;
    logic [Q_W-1:0]   pz;
  } cmd_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // elem_index, elem_value, pos_x, pos_y, pos_z, zero pad
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // op
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // eye_x, eye_y, eye_z, eye_w, clip_x, clip_y, clip_z, clip_w
  logic [OUT_DATA_W-1:0] out_tdata;

  cmd_t                  cmd_q[$];
  cmd_t                  nxt_cmd;
  logic [OUT_DATA_W-1:0] vertex_q[$];
  logic signed [Q_W-1:0] model_m [MAT_N];
  logic signed [Q_W-1:0] proj_m  [MAT_N];
  logic                  in_taken = 1'b0;
  int                    tx_idle  = 0;
  int                    rx_idle  = 0;
  int                    errors   = 0;
  int                    quiet    = 0;

  vertex_model_to_clip_transform u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic longint sat_q(input longint v);
    if (v > longint'(S32_MAX)) return longint'(S32_MAX);
    if (v < longint'(S32_MIN)) return longint'(S32_MIN);
    return v;
  endfunction

  // eye = M * (p, 1), clip = P * eye; products floored by the >>> 16
  function automatic logic [OUT_DATA_W-1:0] transform_vertex(input logic signed [Q_W-1:0] px,
                                                             input logic signed [Q_W-1:0] py,
                                                             input logic signed [Q_W-1:0] pz);
    longint                pos [3];
    longint                eye [4];
    longint                acc;
    logic [OUT_DATA_W-1:0] res;
    pos[0] = longint'(px);
    pos[1] = longint'(py);
    pos[2] = longint'(pz);
    for (int r = 0; r < 4; r++) begin
      acc = longint'(model_m[r + 12]);
      for (int c = 0; c < 3; c++) acc += (pos[c] * longint'(model_m[r + 4 * c])) >>> 16;
      eye[r] = sat_q(acc);
      res[32 * r +: 32] = 32'(eye[r]);
    end
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += (eye[c] * longint'(proj_m[r + 4 * c])) >>> 16;
      res[128 + 32 * r +: 32] = 32'(sat_q(acc));
    end
    return res;
  endfunction

  // mostly small fractions so results stay in range, with full-range and extreme values
  function automatic logic [Q_W-1:0] rand_q();
    logic [Q_W-1:0] v;
    case ($urandom_range(7))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(4))
          0: v = S32_MAX;
          1: v = S32_MIN;
          2: v = '0;
          3: v = Q_ONE;
          default: v = -Q_ONE;
        endcase
      end
      default: begin
        v = $urandom_range(32'h0004_0000);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [Q_W-1:0] val, input logic [Q_W-1:0] px,
                          input logic [Q_W-1:0] py, input logic [Q_W-1:0] pz);
    cmd_t c;
    c.op  = op;
    c.idx = idx;
    c.val = val;
    c.px  = px;
    c.py  = py;
    c.pz  = pz;
    cmd_q.push_back(c);
  endtask

  task automatic gen_random(input int target);
    int             n;
    int             len;
    logic [OP_W-1:0] op;
    n = 0;
    while (n < target) begin
      case ($urandom_range(19))
        0, 1, 2, 3: begin
          // whole matrix reload, in index order
          op = $urandom_range(1) ? OP_LOAD_PROJ : OP_LOAD_MODEL;
          for (int i = 0; i < MAT_N; i++)
            push_cmd(op, IDX_W'(i), rand_q(), $urandom, $urandom, $urandom);
          n += MAT_N;
        end
        4, 5, 6: begin
          op = $urandom_range(1) ? OP_LOAD_PROJ : OP_LOAD_MODEL;
          push_cmd(op, IDX_W'($urandom_range(15)), rand_q(), $urandom, $urandom, $urandom);
          n++;
        end
        7: push_cmd(OP_UNUSED, IDX_W'($urandom_range(15)), $urandom, $urandom, $urandom,
                    $urandom);
        default: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++)
            push_cmd(OP_TRANSFORM, IDX_W'($urandom_range(15)), $urandom, rand_q(), rand_q(),
                     rand_q());
          n += len;
        end
      endcase
    end
  endtask

  task automatic wait_sent();
    while (cmd_q.size() != 0) @(posedge clk);
  endtask

  // driver: a new word goes up only once the current one has been taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
          nxt_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, nxt_cmd.pz, nxt_cmd.py, nxt_cmd.px, nxt_cmd.val, nxt_cmd.idx};
          in_tuser  <= nxt_cmd.op;
        end else begin
          in_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // monitor: result check, then prediction for the input word taken this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, out_tdata);
          errors++;
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (out_tdata[32 * i +: 32] !== vertex_q[0][32 * i +: 32]) begin
              $display("%0t: %s_%c expected %h got %h", $time, (i < 4) ? "eye" : "clip",
                       AXES[8 * (i % 4) +: 8], vertex_q[0][32 * i +: 32],
                       out_tdata[32 * i +: 32]);
              errors++;
            end
          end
          void'(vertex_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        case (in_tuser)
          OP_LOAD_MODEL: model_m[in_tdata[3:0]] = in_tdata[35:4];
          OP_LOAD_PROJ:  proj_m[in_tdata[3:0]]  = in_tdata[35:4];
          OP_TRANSFORM:  vertex_q.push_back(transform_vertex(in_tdata[67:36], in_tdata[99:68],
                                                             in_tdata[131:100]));
          default: ;
        endcase
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAT_N; i++) begin
      model_m[i] = '0;
      proj_m[i]  = '0;
    end
    tx_idle = 17;
    rx_idle = 64;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty matrices give a zero vertex
    push_cmd(OP_TRANSFORM, 4'hF, 32'hDEAD_BEEF, Q_ONE, 32'h0002_0000, 32'h0003_0000);
    push_cmd(OP_UNUSED, 4'd0, 32'h1234_5678, $urandom, $urandom, $urandom);
    // identity on both matrices via the diagonal
    for (int i = 0; i < 4; i++)
      push_cmd(OP_LOAD_MODEL, IDX_W'(5 * i), Q_ONE, $urandom, $urandom, $urandom);
    for (int i = 0; i < 4; i++)
      push_cmd(OP_LOAD_PROJ, IDX_W'(5 * i), Q_ONE, $urandom, $urandom, $urandom);
    push_cmd(OP_TRANSFORM, 4'd0, $urandom, S32_MAX, S32_MAX, S32_MAX);
    push_cmd(OP_TRANSFORM, 4'd7, $urandom, S32_MIN, S32_MIN, S32_MIN);
    // negative value of smallest magnitude, floored product
    push_cmd(OP_TRANSFORM, 4'd3, $urandom, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_8000);
    // translation at the extremes drives eye x and y into saturation
    push_cmd(OP_LOAD_MODEL, 4'd12, S32_MAX, $urandom, $urandom, $urandom);
    push_cmd(OP_LOAD_MODEL, 4'd13, S32_MIN, $urandom, $urandom, $urandom);
    push_cmd(OP_TRANSFORM, 4'd0, $urandom, S32_MAX, S32_MIN, '0);
    // large projection term saturates clip as well
    push_cmd(OP_LOAD_PROJ, 4'd0, S32_MIN, $urandom, $urandom, $urandom);
    push_cmd(OP_LOAD_PROJ, 4'd4, S32_MAX, $urandom, $urandom, $urandom);
    push_cmd(OP_TRANSFORM, 4'd9, $urandom, S32_MAX, S32_MIN, Q_ONE);
    // unused op must not touch the model matrix
    push_cmd(OP_UNUSED, 4'd0, S32_MAX, $urandom, $urandom, $urandom);
    push_cmd(OP_TRANSFORM, 4'd0, $urandom, Q_ONE, -Q_ONE, 32'h0000_8000);

    gen_random(533);
    wait_sent();
    tx_idle = 64;
    rx_idle = 17;
    gen_random(533);
    wait_sent();
    tx_idle = 0;
    rx_idle = 0;
    gen_random(534);
    wait_sent();

    while (in_tvalid || vertex_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
